@@ rtl/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// sit_pkg
// Shared widths, constants and status codes of the segment intersection core.
// ----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

  localparam int CW        = 32;          // coordinate width
  localparam int DW        = CW + 1;      // coordinate difference
  localparam int PW        = 2 * DW;      // product of two differences
  localparam int DETW      = PW + 1;      // det, nm, nl
  localparam int SPLIT     = DW + 1;      // low slice of nm for the partial products
  localparam int NUMW      = DETW + DW;   // nm * dxa
  localparam int QB        = 63;          // quotient bits kept before clamping
  localparam int OFFW      = QB + 1;      // signed clamped offset
  localparam int PXW       = OFFW + 1;    // start point plus offset
  localparam int DDW       = PXW + 1;     // point minus endpoint
  localparam int TOLW      = 31;
  localparam int SQW       = 2 * TOLW;
  localparam int EPS_SHIFT = 20;
  localparam int NDIST     = 8;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_DISJOINT = 3'd1,
    ST_PARALLEL = 3'd2,
    ST_OFF_A    = 3'd3,
    ST_OFF_B    = 3'd4
  } status_t;

  typedef struct packed {
    logic [CW-1:0] ax0;
    logic [CW-1:0] ay0;
    logic [CW-1:0] bx0;
    logic [CW-1:0] by0;
    logic [CW-1:0] bx1;
    logic [CW-1:0] by1;
    logic [DW-1:0] dxa;
    logic [DW-1:0] dya;
  } pts_t;

  typedef struct packed {
    logic v;
    logic dis;
    logic par;
    logic outa;
    logic outb;
    pts_t pt;
  } side_t;

endpackage

`default_nettype wire

@@ rtl/sit_div.sv @@
// ----------------------------------------------------------------------------
// sit_div
// Pipelined restoring divider, one quotient bit per stage, truncating toward
// zero, magnitude clamped to 2^62 with the sign of the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [sit_pkg::NUMW-1:0]   num,
  input  logic        [sit_pkg::DETW-1:0]   den_mag,
  input  logic                              den_neg,
  output logic signed [sit_pkg::OFFW-1:0]   off
);

  localparam int NUMW = sit_pkg::NUMW;
  localparam int DETW = sit_pkg::DETW;
  localparam int QB   = sit_pkg::QB;
  localparam int OFFW = sit_pkg::OFFW;
  localparam logic [QB-1:0] LIM = {1'b1, {(QB-1){1'b0}}};

  typedef struct packed {
    logic [DETW-1:0] rem;
    logic [DETW-1:0] d;
    logic [QB-1:0]   nlo;
    logic [QB-1:0]   q;
    logic            big;
    logic            neg;
  } stage_t;

  stage_t st [0:QB];

  logic [NUMW-1:0] nmag;
  logic [QB-1:0]   qmag;
  logic signed [OFFW-1:0] offm;

  assign nmag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].rem <= DETW'(nmag[NUMW-1:QB]);
      st[0].d   <= den_mag;
      st[0].nlo <= nmag[QB-1:0];
      st[0].q   <= '0;
      st[0].big <= DETW'(nmag[NUMW-1:QB]) >= den_mag;
      st[0].neg <= num[NUMW-1] ^ den_neg;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [DETW:0] sh;
    logic          ge;
    assign sh = {st[k-1].rem, st[k-1].nlo[QB-k]};
    assign ge = sh >= {1'b0, st[k-1].d};
    always_ff @(posedge clk) begin
      if (en) begin
        st[k].rem <= ge ? DETW'(sh - {1'b0, st[k-1].d}) : DETW'(sh);
        st[k].d   <= st[k-1].d;
        st[k].nlo <= st[k-1].nlo;
        st[k].q   <= {st[k-1].q[QB-2:0], ge};
        st[k].big <= st[k-1].big;
        st[k].neg <= st[k-1].neg;
      end
    end
  end

  assign qmag = (st[QB].big || st[QB].q > LIM) ? LIM : st[QB].q;
  assign offm = $signed(OFFW'(qmag));
  assign off  = st[QB].neg ? -offm : offm;

endmodule

`default_nettype wire

@@ rtl/segment_intersection_tol_core.sv @@
// Throughput: one request per cycle; the whole pipeline advances together and
//   holds when the output register is full and not taken.
// Depth is set by the two 63-stage quotient pipelines (one bit per stage).
// Reset: synchronous, clears all valid bits and sets tolerance to 0.
// ----------------------------------------------------------------------------
// segment_intersection_tol_core
// Tolerant 2-D segment crossing test: range check, parallel rejection,
// pipelined division for the crossing point, endpoint nearness checks.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_tol_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sit_pkg::TOLW-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [sit_pkg::CW-1:0] a_start_x,
  input  logic signed [sit_pkg::CW-1:0] a_start_y,
  input  logic signed [sit_pkg::CW-1:0] a_end_x,
  input  logic signed [sit_pkg::CW-1:0] a_end_y,
  input  logic signed [sit_pkg::CW-1:0] b_start_x,
  input  logic signed [sit_pkg::CW-1:0] b_start_y,
  input  logic signed [sit_pkg::CW-1:0] b_end_x,
  input  logic signed [sit_pkg::CW-1:0] b_end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic signed [sit_pkg::CW-1:0] cross_x,
  output logic signed [sit_pkg::CW-1:0] cross_y
);

  localparam int CW    = sit_pkg::CW;
  localparam int DW    = sit_pkg::DW;
  localparam int PW    = sit_pkg::PW;
  localparam int DETW  = sit_pkg::DETW;
  localparam int SPLIT = sit_pkg::SPLIT;
  localparam int NUMW  = sit_pkg::NUMW;
  localparam int QB    = sit_pkg::QB;
  localparam int OFFW  = sit_pkg::OFFW;
  localparam int PXW   = sit_pkg::PXW;
  localparam int DDW   = sit_pkg::DDW;
  localparam int TOLW  = sit_pkg::TOLW;
  localparam int SQW   = sit_pkg::SQW;
  localparam int EPS   = sit_pkg::EPS_SHIFT;
  localparam int ND    = sit_pkg::NDIST;
  localparam int LAST  = QB + 1;
  localparam logic signed [PXW-1:0] SAT_HI = {{(PXW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [PXW-1:0] SAT_LO = {{(PXW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  function automatic logic [DW-1:0] mag_d(input logic signed [DW-1:0] x);
    mag_d = x[DW-1] ? DW'(-x) : DW'(x);
  endfunction

  logic [TOLW-1:0] tolerance;
  logic [SQW-1:0]  tsq;
  logic            adv;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= '0;
    end else if (cfg_valid) begin
      tolerance <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    tsq <= SQW'(tolerance) * SQW'(tolerance);
  end

  // stage 1: differences and widened range check
  logic signed [CW+1:0] te;
  logic signed [CW-1:0] aymin, aymax, bymin, bymax;
  logic signed [DW-1:0] dxa_c, dya_c, dxb_c, dyb_c, dxs_c, dys_c;
  logic                 dis_c;

  assign te    = $signed({3'b000, tolerance});
  assign aymin = (a_start_y < a_end_y) ? a_start_y : a_end_y;
  assign aymax = (a_start_y < a_end_y) ? a_end_y : a_start_y;
  assign bymin = (b_start_y < b_end_y) ? b_start_y : b_end_y;
  assign bymax = (b_start_y < b_end_y) ? b_end_y : b_start_y;
  assign dxa_c = a_end_x - a_start_x;
  assign dya_c = a_end_y - a_start_y;
  assign dxb_c = b_end_x - b_start_x;
  assign dyb_c = b_end_y - b_start_y;
  assign dxs_c = b_start_x - a_start_x;
  assign dys_c = b_start_y - a_start_y;
  assign dis_c = (a_start_x > b_end_x + te) || (a_end_x < b_start_x - te) ||
                 (aymin > bymax + te) || (aymax < bymin - te);

  logic                 v1, dis1;
  sit_pkg::pts_t        pt1;
  logic signed [DW-1:0] dxb1, dyb1, dxs1, dys1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      pt1  <= '{ax0: a_start_x, ay0: a_start_y, bx0: b_start_x, by0: b_start_y,
                bx1: b_end_x, by1: b_end_y, dxa: dxa_c, dya: dya_c};
      dxb1 <= dxb_c;
      dyb1 <= dyb_c;
      dxs1 <= dxs_c;
      dys1 <= dys_c;
      dis1 <= dis_c;
    end
  end

  // stage 2: cross products and norm
  logic [DW-1:0] na, nb, nc, nd, nab, ncd;
  assign na  = mag_d($signed(pt1.dxa));
  assign nb  = mag_d(dxb1);
  assign nc  = mag_d($signed(pt1.dya));
  assign nd  = mag_d(dyb1);
  assign nab = (na > nb) ? na : nb;
  assign ncd = (nc > nd) ? nc : nd;

  logic                 v2, dis2;
  sit_pkg::pts_t        pt2;
  logic signed [PW-1:0] p_bya, p_ayb, p_bys, p_syb, p_ays, p_sya;
  logic [DW-1:0]        norm2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      pt2   <= pt1;
      dis2  <= dis1;
      p_bya <= dxb1 * $signed(pt1.dya);
      p_ayb <= $signed(pt1.dxa) * dyb1;
      p_bys <= dxb1 * dys1;
      p_syb <= dxs1 * dyb1;
      p_ays <= $signed(pt1.dxa) * dys1;
      p_sya <= dxs1 * $signed(pt1.dya);
      norm2 <= (nab > ncd) ? nab : ncd;
    end
  end

  // stage 3: det, nm, nl, norm squared
  logic                   v3, dis3;
  sit_pkg::pts_t          pt3;
  logic signed [DETW-1:0] det3, nm3, nl3;
  logic [PW-1:0]          nsq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      pt3  <= pt2;
      dis3 <= dis2;
      det3 <= DETW'(p_bya) - DETW'(p_ayb);
      nm3  <= DETW'(p_bys) - DETW'(p_syb);
      nl3  <= DETW'(p_ays) - DETW'(p_sya);
      nsq3 <= PW'(norm2) * PW'(norm2);
    end
  end

  // stage 4: parallel test, parameter range tests, partial products
  logic [DETW-1:0] dmag_c, nmm_c, nlm_c;
  logic            par_c, outa_c, outb_c;

  assign dmag_c = det3[DETW-1] ? DETW'(-det3) : DETW'(det3);
  assign nmm_c  = nm3[DETW-1] ? DETW'(-nm3) : DETW'(nm3);
  assign nlm_c  = nl3[DETW-1] ? DETW'(-nl3) : DETW'(nl3);
  assign par_c  = {dmag_c, {EPS{1'b0}}} <= (DETW+EPS)'(nsq3);
  assign outa_c = (nm3 != '0) && ((nm3[DETW-1] != det3[DETW-1]) || (nmm_c > dmag_c));
  assign outb_c = (nl3 != '0) && ((nl3[DETW-1] != det3[DETW-1]) || (nlm_c > dmag_c));

  logic                          v4, dis4, par4, outa4, outb4, dneg4;
  sit_pkg::pts_t                 pt4;
  logic [DETW-1:0]               dmag4;
  logic signed [SPLIT+DW:0]      plox4, ploy4;
  logic signed [DETW-SPLIT+DW-1:0] phix4, phiy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
    if (adv) begin
      pt4   <= pt3;
      dis4  <= dis3;
      par4  <= par_c;
      outa4 <= outa_c;
      outb4 <= outb_c;
      dneg4 <= det3[DETW-1];
      dmag4 <= dmag_c;
      plox4 <= $signed({1'b0, nm3[SPLIT-1:0]}) * $signed(pt3.dxa);
      ploy4 <= $signed({1'b0, nm3[SPLIT-1:0]}) * $signed(pt3.dya);
      phix4 <= $signed(nm3[DETW-1:SPLIT]) * $signed(pt3.dxa);
      phiy4 <= $signed(nm3[DETW-1:SPLIT]) * $signed(pt3.dya);
    end
  end

  // stage 5: full numerators, then the dividers
  sit_pkg::side_t         sb [0:LAST];
  logic signed [NUMW-1:0] numx5, numy5;
  logic [DETW-1:0]        dmag5;
  logic                   dneg5;
  logic signed [OFFW-1:0] offx, offy;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LAST; k++) begin
        sb[k].v <= 1'b0;
      end
    end else if (adv) begin
      sb[0].v <= v4;
      for (int k = 1; k <= LAST; k++) begin
        sb[k].v <= sb[k-1].v;
      end
    end
    if (adv) begin
      sb[0].dis  <= dis4;
      sb[0].par  <= par4;
      sb[0].outa <= outa4;
      sb[0].outb <= outb4;
      sb[0].pt   <= pt4;
      for (int k = 1; k <= LAST; k++) begin
        sb[k].dis  <= sb[k-1].dis;
        sb[k].par  <= sb[k-1].par;
        sb[k].outa <= sb[k-1].outa;
        sb[k].outb <= sb[k-1].outb;
        sb[k].pt   <= sb[k-1].pt;
      end
      numx5 <= $signed({phix4, {SPLIT{1'b0}}}) + plox4;
      numy5 <= $signed({phiy4, {SPLIT{1'b0}}}) + ploy4;
      dmag5 <= dmag4;
      dneg5 <= dneg4;
    end
  end

  sit_div u_div_x (
    .clk     (clk),
    .en      (adv),
    .num     (numx5),
    .den_mag (dmag5),
    .den_neg (dneg5),
    .off     (offx)
  );

  sit_div u_div_y (
    .clk     (clk),
    .en      (adv),
    .num     (numy5),
    .den_mag (dmag5),
    .den_neg (dneg5),
    .off     (offy)
  );

  // stage 6: crossing point and distances to the four endpoints
  sit_pkg::side_t        sl;
  logic signed [PXW-1:0] px_c, py_c;
  logic signed [DDW-1:0] dd_c [0:ND-1];

  assign sl      = sb[LAST];
  assign px_c    = PXW'($signed(sl.pt.ax0)) + PXW'(offx);
  assign py_c    = PXW'($signed(sl.pt.ay0)) + PXW'(offy);
  assign dd_c[0] = DDW'(offx);
  assign dd_c[1] = DDW'(offy);
  assign dd_c[2] = DDW'(offx) - DDW'($signed(sl.pt.dxa));
  assign dd_c[3] = DDW'(offy) - DDW'($signed(sl.pt.dya));
  assign dd_c[4] = DDW'(px_c) - DDW'($signed(sl.pt.bx0));
  assign dd_c[5] = DDW'(py_c) - DDW'($signed(sl.pt.by0));
  assign dd_c[6] = DDW'(px_c) - DDW'($signed(sl.pt.bx1));
  assign dd_c[7] = DDW'(py_c) - DDW'($signed(sl.pt.by1));

  logic                  v6, dis6, par6, outa6, outb6;
  logic signed [PXW-1:0] px6, py6;
  logic signed [DDW-1:0] dd6 [0:ND-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= sl.v;
    end
    if (adv) begin
      dis6  <= sl.dis;
      par6  <= sl.par;
      outa6 <= sl.outa;
      outb6 <= sl.outb;
      px6   <= px_c;
      py6   <= py_c;
      for (int i = 0; i < ND; i++) begin
        dd6[i] <= dd_c[i];
      end
    end
  end

  // stage 7: magnitudes against tolerance, saturation
  logic [DDW-1:0] dm_c [0:ND-1];
  for (genvar i = 0; i < ND; i++) begin : g_mag
    assign dm_c[i] = dd6[i][DDW-1] ? DDW'(-dd6[i]) : DDW'(dd6[i]);
  end

  logic                 v7, dis7, par7, outa7, outb7;
  logic signed [CW-1:0] sx7, sy7;
  logic [ND-1:0]        ok7;
  logic [TOLW-1:0]      mg7 [0:ND-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
    if (adv) begin
      dis7  <= dis6;
      par7  <= par6;
      outa7 <= outa6;
      outb7 <= outb6;
      sx7   <= (px6 > SAT_HI) ? CW'(SAT_HI) : (px6 < SAT_LO) ? CW'(SAT_LO) : CW'(px6);
      sy7   <= (py6 > SAT_HI) ? CW'(SAT_HI) : (py6 < SAT_LO) ? CW'(SAT_LO) : CW'(py6);
      for (int i = 0; i < ND; i++) begin
        ok7[i] <= dm_c[i] <= DDW'(tolerance);
        mg7[i] <= dm_c[i][TOLW-1:0];
      end
    end
  end

  // stage 8: squares
  logic                 v8, dis8, par8, outa8, outb8;
  logic signed [CW-1:0] sx8, sy8;
  logic [ND-1:0]        ok8;
  logic [SQW-1:0]       sq8 [0:ND-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= v7;
    end
    if (adv) begin
      dis8  <= dis7;
      par8  <= par7;
      outa8 <= outa7;
      outb8 <= outb7;
      sx8   <= sx7;
      sy8   <= sy7;
      ok8   <= ok7;
      for (int i = 0; i < ND; i++) begin
        sq8[i] <= SQW'(mg7[i]) * SQW'(mg7[i]);
      end
    end
  end

  // stage 9: nearness and status
  logic [ND/2-1:0]  nr;
  sit_pkg::status_t st_c;

  for (genvar j = 0; j < ND/2; j++) begin : g_near
    assign nr[j] = ok8[2*j] && ok8[2*j+1] &&
                   ((SQW+1)'(sq8[2*j]) + (SQW+1)'(sq8[2*j+1]) <= (SQW+1)'(tsq));
  end

  always_comb begin
    priority if (dis8) begin
      st_c = sit_pkg::ST_DISJOINT;
    end else if (par8) begin
      st_c = sit_pkg::ST_PARALLEL;
    end else if (outa8 && !nr[0] && !nr[1]) begin
      st_c = sit_pkg::ST_OFF_A;
    end else if (outb8 && !nr[2] && !nr[3]) begin
      st_c = sit_pkg::ST_OFF_B;
    end else begin
      st_c = sit_pkg::ST_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v8;
    end
    if (adv) begin
      status  <= st_c;
      cross_x <= (st_c == sit_pkg::ST_HIT) ? sx8 : '0;
      cross_y <= (st_c == sit_pkg::ST_HIT) ? sy8 : '0;
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != sit_pkg::ST_HIT |-> cross_x == '0 && cross_y == '0)
    else $error("nonzero point on a miss");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v1) && $stable(sb[LAST].v) && $stable(v8) && $stable(out_valid))
    else $error("pipeline moved during stall");

  a_det_live: assert property (@(posedge clk) disable iff (rst)
    sb[0].v && !sb[0].dis && !sb[0].par |-> dmag5 != '0)
    else $error("zero determinant reached the divider");

endmodule

`default_nettype wire
